// File: hw/rtl/tinylfu_frequency_sketch_top_defines.svh
// Assertion macros for the TinyLFU frequency sketch checker.
// Used by tlfs_checker.sv; expects signals named clk and rst in scope.
`ifndef TINYLFU_FREQUENCY_SKETCH_TOP_DEFINES_SVH
`define TINYLFU_FREQUENCY_SKETCH_TOP_DEFINES_SVH

// Implication in the same cycle, ignored while in reset.
`define TLFS_ASSERT_NOW(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("tlfs assertion failed");

// Implication in the next cycle, ignored while in reset.
`define TLFS_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("tlfs assertion failed");

// Implication in the next cycle that also holds across reset.
`define TLFS_ASSERT_ALWAYS(label, ante, cons) \
  label: assert property (@(posedge clk) (ante) |=> (cons)) \
    else $error("tlfs assertion failed");

`endif

// File: hw/rtl/tlfs_pkg.sv
// Shared constants, types and hash helpers for the TinyLFU frequency sketch.
// No dependencies; imported by every module of the block.
`timescale 1ns / 1ps
`default_nettype none
package tlfs_pkg;

  localparam int DEFAULT_ROWS           = 4;
  localparam int DEFAULT_MAX_WIDTH_LOG2 = 12;

  localparam logic [63:0] FNV_PRIME = 64'h0000_0100_0000_01b3;
  localparam logic [63:0] MIX_A     = 64'hbf58_476d_1ce4_e5b9;
  localparam logic [63:0] MIX_B     = 64'h94d0_49bb_1331_11eb;
  localparam logic [63:0] ROW_SEED  = 64'h9e37_79b9_7f4a_7c15;
  localparam logic [63:0] ROW_STEP  = 64'h27d4_eb2f_1656_67c5;
  localparam logic [63:0] GATE_SEED = 64'hcbf2_9ce4_8422_2325;
  localparam logic [3:0]  COUNT_MAX = 4'd15;

  localparam logic [3:0]  WIDTH_RESET    = 4'd12;
  localparam logic [31:0] INTERVAL_RESET = 32'd65536;

  // Configuration register indexes.
  localparam logic CFG_WIDTH_LOG2 = 1'b0;
  localparam logic CFG_DECAY      = 1'b1;

  typedef struct packed {
    logic [3:0]  width_log2;
    logic [31:0] decay_interval;
  } cfg_t;

  typedef enum logic [1:0] {
    F_BYTES,
    F_MUL,
    F_MOD,
    F_PUSH
  } front_state_t;

  typedef enum logic [2:0] {
    B_SWEEP,
    B_IDLE,
    B_READ,
    B_ACT,
    B_SET2,
    B_RES
  } back_state_t;

  // Seed of hash j: the first rows hashes are sketch rows, then two doorkeeper hashes.
  function automatic logic [63:0] hash_seed(input int j, input int rows);
    logic [63:0] s;
    if (j < rows) begin
      s = ROW_SEED + 64'(j) * ROW_STEP;
    end else begin
      s = GATE_SEED + 64'(j - rows) * FNV_PRIME;
    end
    return s;
  endfunction

  // One FNV-1a step; the prime is 2^40 + 0x1b3, so the product is shifts and adds.
  function automatic logic [63:0] fnv_step(input logic [63:0] x, input logic [7:0] b);
    logic [63:0] y;
    y = x ^ {56'd0, b};
    return (y << 40) + y + (y << 1) + (y << 4) + (y << 5) + (y << 7) + (y << 8);
  endfunction

endpackage
`default_nettype wire

// File: hw/rtl/tinylfu_frequency_sketch_top.sv
// TinyLFU frequency sketch: a count-min sketch of 4-bit counters behind a
// two-hash doorkeeper bloom filter. A key arrives one byte per transfer on the
// push side. On the byte marked last the front end finishes ROWS + 2 hashes on
// one shared 32x32 multiplier, then reduces the two doorkeeper hashes modulo
// ROWS one byte per cycle; full is high from the last byte until the command
// is taken by the queue. Finished keys wait in a two-entry command queue. The
// back end steps each command through read, act, an optional second doorkeeper
// write and result states on the counter banks and doorkeeper memory, then
// offers one result on the pop side: admitted for an observe, freq_estimate for
// a query. After reset, and whenever an observe finds the decay interval
// reached, the back end sweeps every address of both memories one address per
// cycle, halving counters (clearing them after reset) and clearing the
// doorkeeper; the front end keeps taking bytes meanwhile until the queue fills.
// Configuration writes are taken at any time but belong to idle periods.
// Depends on tlfs_pkg, tlfs_front, tlfs_cmd_fifo and tlfs_back.
`timescale 1ns / 1ps
`default_nettype none
module tinylfu_frequency_sketch_top #(
  parameter int ROWS           = tlfs_pkg::DEFAULT_ROWS,
  parameter int MAX_WIDTH_LOG2 = tlfs_pkg::DEFAULT_MAX_WIDTH_LOG2
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_we,
  input  logic        cfg_index,
  input  logic [31:0] cfg_data,
  input  logic        push,
  output logic        full,
  input  logic        func,
  input  logic [7:0]  key_byte,
  input  logic        key_last,
  output logic        empty,
  input  logic        pop,
  output logic        admitted,
  output logic [3:0]  freq_estimate
);
  import tlfs_pkg::*;

  // Command layout: row indexes, two doorkeeper addresses, two bit selects, func.
  localparam int RW = (ROWS > 1) ? $clog2(ROWS) : 1;
  localparam int CW = (ROWS + 2) * MAX_WIDTH_LOG2 + 2 * RW + 1;

  cfg_t          cfg;
  logic          cmd_valid, cmd_ready, cmd_empty, cmd_pop;
  logic [CW-1:0] cmd_in, cmd_out;

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.width_log2     <= WIDTH_RESET;
      cfg.decay_interval <= INTERVAL_RESET;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_WIDTH_LOG2: cfg.width_log2     <= cfg_data[3:0];
        CFG_DECAY:      cfg.decay_interval <= cfg_data;
        default:        cfg.decay_interval <= cfg.decay_interval;
      endcase
    end
  end

  // Hashing front end: absorbs bytes, finishes hashes and forms table indexes.
  tlfs_front #(
    .ROWS(ROWS), .MAX_WIDTH_LOG2(MAX_WIDTH_LOG2), .CW(CW)
  ) u_front (
    .clk(clk), .rst(rst), .cfg(cfg),
    .push(push), .full(full), .func(func), .key_byte(key_byte), .key_last(key_last),
    .cmd_valid(cmd_valid), .cmd_ready(cmd_ready), .cmd_data(cmd_in)
  );

  // The queue lets the front end finish the next key while the back end sweeps.
  tlfs_cmd_fifo #(.WIDTH(CW)) u_fifo (
    .clk(clk), .rst(rst),
    .wr_valid(cmd_valid), .wr_ready(cmd_ready), .wr_data(cmd_in),
    .rd_pop(cmd_pop), .rd_empty(cmd_empty), .rd_data(cmd_out)
  );

  // Table back end: reads and updates the sketch and holds the result.
  tlfs_back #(
    .ROWS(ROWS), .MAX_WIDTH_LOG2(MAX_WIDTH_LOG2), .CW(CW)
  ) u_back (
    .clk(clk), .rst(rst), .cfg(cfg),
    .cmd_empty(cmd_empty), .cmd_data(cmd_out), .cmd_pop(cmd_pop),
    .empty(empty), .pop(pop), .admitted(admitted), .freq_estimate(freq_estimate)
  );

endmodule
`default_nettype wire

// File: hw/rtl/tlfs_front.sv
// Front end: folds key bytes into the hashes, finishes them and builds commands.
// Depends on tlfs_pkg; feeds tlfs_cmd_fifo.
`timescale 1ns / 1ps
`default_nettype none
module tlfs_front #(
  parameter int ROWS           = 4,
  parameter int MAX_WIDTH_LOG2 = 12,
  parameter int CW             = 1
) (
  input  logic              clk,
  input  logic              rst,
  input  tlfs_pkg::cfg_t    cfg,
  input  logic              push,
  output logic              full,
  input  logic              func,
  input  logic [7:0]        key_byte,
  input  logic              key_last,
  output logic              cmd_valid,
  input  logic              cmd_ready,
  output logic [CW-1:0]     cmd_data
);
  import tlfs_pkg::*;

  localparam int HN  = ROWS + 2;
  localparam int KW  = $clog2(HN);
  localparam int MW  = MAX_WIDTH_LOG2;
  localparam int RW  = (ROWS > 1) ? $clog2(ROWS) : 1;
  localparam int WUW = $clog2(MAX_WIDTH_LOG2 + 1);
  localparam int GB  = (ROWS + 2) * MW;

  front_state_t state, state_next;

  logic [63:0] acc [HN];
  logic [63:0] fin [HN];
  logic        func_q;
  logic [KW-1:0] k;
  logic        cb;
  logic [2:0]  ph;
  logic [63:0] opa, p, macc;
  logic [63:0] md [2];
  logic [RW-1:0] rr [2];
  logic [3:0]  mc;
  logic [MW+RW-1:0] gidx [2];

  logic [4:0]  wl5;
  logic [WUW-1:0] w;
  logic [MW-1:0] mask;
  logic [63:0] mconst, mfull, mfin;
  logic [31:0] mul_a, mul_b;
  logic        accept;

  function automatic logic [RW-1:0] mod_byte(input logic [RW-1:0] r, input logic [7:0] b);
    logic [RW:0] t;
    logic [RW-1:0] q;
    q = r;
    for (int i = 7; i >= 0; i--) begin
      t = {q, b[i]};
      if (t >= (RW+1)'(ROWS)) begin
        t = t - (RW+1)'(ROWS);
      end
      q = t[RW-1:0];
    end
    return q;
  endfunction

  // Width in use, clamped into the supported range.
  always_comb begin
    wl5 = {1'b0, cfg.width_log2};
    if (wl5 == 5'd0) begin
      wl5 = 5'd1;
    end else if (wl5 > 5'(MAX_WIDTH_LOG2)) begin
      wl5 = 5'(MAX_WIDTH_LOG2);
    end
    w = WUW'(wl5);
    for (int i = 0; i < MW; i++) begin
      mask[i] = (i < int'(w));
    end
  end

  assign accept = push && !full;
  assign mconst = cb ? MIX_B : MIX_A;
  assign mul_a  = (ph == 3'd2) ? opa[63:32] : opa[31:0];
  assign mul_b  = (ph == 3'd3) ? mconst[63:32] : mconst[31:0];
  assign mfull  = macc + (p << 32);
  assign mfin   = mfull ^ (mfull >> 31);

  always_comb begin
    state_next = state;
    unique case (state)
      F_BYTES: if (accept && key_last) state_next = F_MUL;
      F_MUL:   if (ph == 3'd4 && cb && k == KW'(HN - 1)) state_next = F_MOD;
      F_MOD:   if (mc == 4'd8) state_next = F_PUSH;
      F_PUSH:  if (cmd_ready) state_next = F_BYTES;
      default: state_next = F_BYTES;
    endcase
  end

  always_comb begin
    full      = 1'b1;
    cmd_valid = 1'b0;
    unique case (state)
      F_BYTES: full = 1'b0;
      F_PUSH:  cmd_valid = 1'b1;
      default: full = 1'b1;
    endcase
  end

  // The doorkeeper index is the flat bit number (h >> w) mod ROWS * 2^w + (h & mask);
  // its low MW bits select the word and the bits above select the bit in it.
  always_comb begin
    cmd_data = '0;
    cmd_data[CW-1] = func_q;
    for (int r = 0; r < ROWS; r++) begin
      cmd_data[r*MW +: MW] = fin[r][MW-1:0] & mask;
    end
    for (int j = 0; j < 2; j++) begin
      gidx[j] = ((MW+RW)'(rr[j]) << w) | (MW+RW)'(fin[ROWS+j][MW-1:0] & mask);
      cmd_data[(ROWS+j)*MW +: MW] = gidx[j][MW-1:0];
      cmd_data[GB + j*RW +: RW]   = gidx[j][MW +: RW];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= F_BYTES;
      for (int j = 0; j < HN; j++) begin
        acc[j] <= hash_seed(j, ROWS);
      end
    end else begin
      state <= state_next;
      if (accept) begin
        for (int j = 0; j < HN; j++) begin
          if (key_last) begin
            fin[j] <= fnv_step(acc[j], key_byte);
            acc[j] <= hash_seed(j, ROWS);
          end else begin
            acc[j] <= fnv_step(acc[j], key_byte);
          end
        end
      end
      if (state == F_MUL && ph == 3'd4 && cb) begin
        fin[k] <= mfin;
      end
    end
  end

  // Finishing sequencer and gate index reduction; payload only, no reset.
  always_ff @(posedge clk) begin
    if (accept && key_last) begin
      func_q <= func;
      k  <= '0;
      ph <= '0;
      cb <= 1'b0;
      mc <= '0;
    end
    if (state == F_MUL) begin
      p <= 64'(mul_a) * 64'(mul_b);
      unique case (ph)
        3'd0: opa <= cb ? (macc ^ (macc >> 27)) : (fin[k] ^ (fin[k] >> 30));
        3'd2: macc <= p;
        3'd3: macc <= mfull;
        3'd4: macc <= mfull;
        default: macc <= macc;
      endcase
      if (ph == 3'd4) begin
        ph <= '0;
        cb <= !cb;
        if (cb) begin
          k <= k + KW'(1);
        end
      end else begin
        ph <= ph + 3'd1;
      end
    end
    if (state == F_MOD) begin
      mc <= mc + 4'd1;
      for (int j = 0; j < 2; j++) begin
        if (mc == 4'd0) begin
          md[j] <= fin[ROWS+j] >> w;
          rr[j] <= '0;
        end else begin
          md[j] <= md[j] << 8;
          rr[j] <= mod_byte(rr[j], md[j][63:56]);
        end
      end
    end
  end

endmodule
`default_nettype wire

// File: hw/rtl/tlfs_cmd_fifo.sv
// Two-entry command queue between the hashing front end and the table back end.
// Depends on tlfs_pkg for style only; width is set by the instantiating module.
`timescale 1ns / 1ps
`default_nettype none
module tlfs_cmd_fifo #(
  parameter int WIDTH = 1
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             wr_valid,
  output logic             wr_ready,
  input  logic [WIDTH-1:0] wr_data,
  input  logic             rd_pop,
  output logic             rd_empty,
  output logic [WIDTH-1:0] rd_data
);
  import tlfs_pkg::*;

  logic [WIDTH-1:0] slot [2];
  logic       wp, rp;
  logic [1:0] cnt;
  logic       do_wr, do_rd;

  assign wr_ready = (cnt != 2'd2);
  assign rd_empty = (cnt == 2'd0);
  assign rd_data  = slot[rp];
  assign do_wr    = wr_valid && wr_ready;
  assign do_rd    = rd_pop && !rd_empty;

  always_ff @(posedge clk) begin
    if (rst) begin
      wp  <= 1'b0;
      rp  <= 1'b0;
      cnt <= 2'd0;
    end else begin
      if (do_wr) wp <= !wp;
      if (do_rd) rp <= !rp;
      cnt <= cnt + 2'(do_wr) - 2'(do_rd);
    end
  end

  always_ff @(posedge clk) begin
    if (do_wr) begin
      slot[wp] <= wr_data;
    end
  end

endmodule
`default_nettype wire

// File: hw/rtl/tlfs_back.sv
// Back end: counter banks, doorkeeper memory, decay sweep and the result register.
// Depends on tlfs_pkg; takes commands from tlfs_cmd_fifo.
`timescale 1ns / 1ps
`default_nettype none
module tlfs_back #(
  parameter int ROWS           = 4,
  parameter int MAX_WIDTH_LOG2 = 12,
  parameter int CW             = 1
) (
  input  logic           clk,
  input  logic           rst,
  input  tlfs_pkg::cfg_t cfg,
  input  logic           cmd_empty,
  input  logic [CW-1:0]  cmd_data,
  output logic           cmd_pop,
  output logic           empty,
  input  logic           pop,
  output logic           admitted,
  output logic [3:0]     freq_estimate
);
  import tlfs_pkg::*;

  localparam int MW   = MAX_WIDTH_LOG2;
  localparam int SPAN = 1 << MAX_WIDTH_LOG2;
  localparam int RW   = (ROWS > 1) ? $clog2(ROWS) : 1;
  localparam int GB   = (ROWS + 2) * MW;

  back_state_t state, state_next;

  logic [3:0]      cmem [ROWS][SPAN];
  logic [ROWS-1:0] dmem [SPAN];

  logic [MW-1:0] c_raddr [ROWS];
  logic [MW-1:0] c_waddr [ROWS];
  logic [3:0]    c_wdata [ROWS];
  logic [3:0]    c_rdata [ROWS];
  logic          c_we;
  logic [MW-1:0] d_raddr0, d_raddr1, d_waddr;
  logic [ROWS-1:0] d_rdata0, d_rdata1, d_wdata;
  logic          d_we;

  logic          cq_func;
  logic [MW-1:0] cq_row [ROWS];
  logic [MW-1:0] cq_ga  [2];
  logic [RW-1:0] cq_gb  [2];

  logic [MW:0]   sa;
  logic [MW-1:0] sweep_prev;
  logic          clr, hold, out_full;
  logic [31:0]   ops;
  logic          res_adm;
  logic [3:0]    res_freq;

  logic          due, hit, same, load_out;
  logic [ROWS-1:0] bm0, bm1, word0, word1;
  logic [3:0]    minv;

  assign due = !cmd_data[CW-1] && (cfg.decay_interval != 32'd0)
               && (ops >= cfg.decay_interval);
  assign sweep_prev = MW'(sa - (MW+1)'(1));
  assign bm0   = ROWS'(1) << cq_gb[0];
  assign bm1   = ROWS'(1) << cq_gb[1];
  assign same  = (cq_ga[0] == cq_ga[1]);
  assign hit   = d_rdata0[cq_gb[0]] && d_rdata1[cq_gb[1]];
  assign word0 = d_rdata0 | bm0 | (same ? bm1 : '0);
  assign word1 = same ? word0 : (d_rdata1 | bm1);
  assign empty = !out_full;

  always_comb begin
    minv = COUNT_MAX;
    for (int r = 0; r < ROWS; r++) begin
      if (c_rdata[r] < minv) minv = c_rdata[r];
    end
  end

  always_comb begin
    state_next = state;
    unique case (state)
      B_SWEEP: if (sa == (MW+1)'(SPAN)) state_next = hold ? B_READ : B_IDLE;
      B_IDLE:  if (!cmd_empty) state_next = due ? B_SWEEP : B_READ;
      B_READ:  state_next = B_ACT;
      B_ACT:   state_next = (cq_func || hit) ? B_RES : B_SET2;
      B_SET2:  state_next = B_RES;
      B_RES:   if (!out_full) state_next = B_IDLE;
      default: state_next = B_IDLE;
    endcase
  end

  always_comb begin
    cmd_pop  = 1'b0;
    c_we     = 1'b0;
    d_we     = 1'b0;
    load_out = 1'b0;
    d_raddr0 = cq_ga[0];
    d_raddr1 = cq_ga[1];
    d_waddr  = cq_ga[0];
    d_wdata  = word0;
    for (int r = 0; r < ROWS; r++) begin
      c_raddr[r] = cq_row[r];
      c_waddr[r] = cq_row[r];
      c_wdata[r] = (c_rdata[r] == COUNT_MAX) ? COUNT_MAX : c_rdata[r] + 4'd1;
    end
    unique case (state)
      B_SWEEP: begin
        c_we    = (sa != '0);
        d_we    = (sa != '0);
        d_waddr = sweep_prev;
        d_wdata = '0;
        for (int r = 0; r < ROWS; r++) begin
          c_raddr[r] = sa[MW-1:0];
          c_waddr[r] = sweep_prev;
          c_wdata[r] = clr ? 4'd0 : (c_rdata[r] >> 1);
        end
      end
      B_IDLE: cmd_pop = !cmd_empty;
      B_ACT: begin
        c_we = !cq_func && hit;
        d_we = !cq_func && !hit;
      end
      B_SET2: begin
        d_we    = 1'b1;
        d_waddr = cq_ga[1];
        d_wdata = word1;
      end
      B_RES:   load_out = !out_full;
      default: cmd_pop = 1'b0;
    endcase
  end

  // Memories with registered read data.
  always_ff @(posedge clk) begin
    for (int r = 0; r < ROWS; r++) begin
      if (c_we) cmem[r][c_waddr[r]] <= c_wdata[r];
      c_rdata[r] <= cmem[r][c_raddr[r]];
    end
    if (d_we) dmem[d_waddr] <= d_wdata;
    d_rdata0 <= dmem[d_raddr0];
    d_rdata1 <= dmem[d_raddr1];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= B_SWEEP;
      sa       <= '0;
      clr      <= 1'b1;
      hold     <= 1'b0;
      ops      <= '0;
      out_full <= 1'b0;
    end else begin
      state <= state_next;
      if (load_out) begin
        out_full <= 1'b1;
      end else if (pop) begin
        out_full <= 1'b0;
      end
      if (state == B_SWEEP) begin
        if (sa == (MW+1)'(SPAN)) begin
          sa   <= '0;
          clr  <= 1'b0;
          hold <= 1'b0;
        end else begin
          sa <= sa + (MW+1)'(1);
        end
      end
      if (state == B_IDLE && !cmd_empty && !cmd_data[CW-1]) begin
        if (due) begin
          ops  <= 32'd1;
          hold <= 1'b1;
        end else begin
          ops <= ops + 32'd1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd_pop) begin
      cq_func <= cmd_data[CW-1];
      for (int r = 0; r < ROWS; r++) begin
        cq_row[r] <= cmd_data[r*MW +: MW];
      end
      for (int j = 0; j < 2; j++) begin
        cq_ga[j] <= cmd_data[(ROWS+j)*MW +: MW];
        cq_gb[j] <= cmd_data[GB + j*RW +: RW];
      end
    end
    if (state == B_ACT) begin
      res_adm  <= !cq_func && hit;
      res_freq <= cq_func ? minv : 4'd0;
    end
    if (load_out) begin
      admitted      <= res_adm;
      freq_estimate <= res_freq;
    end
  end

endmodule
`default_nettype wire

// File: hw/rtl/tlfs_checker.sv
// Port-level checks for the TinyLFU frequency sketch, bound to the top level.
// Depends on tinylfu_frequency_sketch_top_defines.svh for the assertion macros.
`timescale 1ns / 1ps
`default_nettype none
`include "tinylfu_frequency_sketch_top_defines.svh"
module tlfs_checker (
  input wire logic       clk,
  input wire logic       rst,
  input wire logic       push,
  input wire logic       full,
  input wire logic       key_last,
  input wire logic       pop,
  input wire logic       empty,
  input wire logic       admitted,
  input wire logic [3:0] freq_estimate
);
  import tlfs_pkg::*;

  // No result is offered right after reset.
  `TLFS_ASSERT_ALWAYS(a_empty_after_reset, rst, empty)
  // A waiting result stays put until it is transferred.
  `TLFS_ASSERT_NEXT(a_result_holds, !empty && !pop, !empty && $stable(admitted) && $stable(freq_estimate))
  // A result is never both admitted and carrying an estimate.
  `TLFS_ASSERT_NOW(a_one_kind, !empty && admitted, freq_estimate == 4'd0)
  // The front end only stalls after taking the last byte of a key.
  `TLFS_ASSERT_NOW(a_full_after_last, $rose(full), $past(push && key_last))

endmodule

bind tinylfu_frequency_sketch_top tlfs_checker u_checker (.*);
`default_nettype wire

// File: tb/sketch_checker.sv
`timescale 1ns / 1ps
// Checker for the TinyLFU frequency sketch: watches the config, key byte and
// result channels, keeps its own copy of the sketch state and compares results.
// Depends on tlfs_pkg for constants and register indexes.
module sketch_checker
  import tlfs_pkg::*;
#(
  parameter int ROWS           = DEFAULT_ROWS,
  parameter int MAX_WIDTH_LOG2 = DEFAULT_MAX_WIDTH_LOG2
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_we,
  input  logic        cfg_index,
  input  logic [31:0] cfg_data,
  input  logic        push,
  input  logic        full,
  input  logic        func,
  input  logic [7:0]  key_byte,
  input  logic        key_last,
  input  logic        empty,
  input  logic        pop,
  input  logic        admitted,
  input  logic [3:0]  freq_estimate,
  output int          mismatches,
  output int          pending
);

  localparam int SPAN  = 1 << MAX_WIDTH_LOG2;
  localparam int DEPTH = ROWS * SPAN;

  typedef struct packed {
    logic       admit;
    logic [3:0] freq;
  } outcome_t;

  outcome_t    outcome_q[$];
  logic [3:0]  counters[DEPTH];
  logic        gate_bits[DEPTH];
  logic [63:0] hash_acc[ROWS + 2];
  logic [3:0]  width_reg;
  logic [31:0] interval_reg;
  logic [31:0] observes;

  initial begin
    mismatches = 0;
    pending    = 0;
  end

  function automatic logic [63:0] splitmix(input logic [63:0] h);
    logic [63:0] x;
    x = h ^ (h >> 30);
    x = x * MIX_A;
    x = x ^ (x >> 27);
    x = x * MIX_B;
    return x ^ (x >> 31);
  endfunction

  // Rows come first, then the two doorkeeper hashes.
  task automatic reseed();
    for (int j = 0; j < ROWS + 2; j++) begin
      if (j < ROWS) hash_acc[j] = ROW_SEED + 64'(j) * ROW_STEP;
      else hash_acc[j] = GATE_SEED + 64'(j - ROWS) * FNV_PRIME;
    end
  endtask

  task automatic absorb_byte(input logic f, input logic [7:0] b, input logic last);
    int          w;
    logic [63:0] row_mask;
    logic [63:0] gate_mod;
    int          row_at[ROWS];
    int          gate_at[2];
    logic [3:0]  lowest;
    outcome_t    res;
    for (int j = 0; j < ROWS + 2; j++) hash_acc[j] = (hash_acc[j] ^ {56'd0, b}) * FNV_PRIME;
    if (!last) return;
    w = int'(width_reg);
    if (w < 1) w = 1;
    if (w > MAX_WIDTH_LOG2) w = MAX_WIDTH_LOG2;
    row_mask = (64'd1 << w) - 64'd1;
    gate_mod = 64'(ROWS) << w;
    for (int k = 0; k < ROWS; k++) row_at[k] = k * SPAN + int'(splitmix(hash_acc[k]) & row_mask);
    for (int k = 0; k < 2; k++) gate_at[k] = int'(splitmix(hash_acc[ROWS + k]) % gate_mod);
    reseed();
    res = '0;
    if (f) begin
      lowest = COUNT_MAX;
      for (int k = 0; k < ROWS; k++) if (counters[row_at[k]] < lowest) lowest = counters[row_at[k]];
      res.freq = lowest;
    end else begin
      // Decay covers the whole store, not only the width in use.
      if (interval_reg != 0 && observes >= interval_reg) begin
        for (int i = 0; i < DEPTH; i++) begin
          counters[i]  = counters[i] >> 1;
          gate_bits[i] = 1'b0;
        end
        observes = 0;
      end
      observes = observes + 1;
      if (gate_bits[gate_at[0]] && gate_bits[gate_at[1]]) begin
        for (int k = 0; k < ROWS; k++)
          if (counters[row_at[k]] < COUNT_MAX) counters[row_at[k]] = counters[row_at[k]] + 1;
        res.admit = 1'b1;
      end else begin
        gate_bits[gate_at[0]] = 1'b1;
        gate_bits[gate_at[1]] = 1'b1;
      end
    end
    outcome_q.push_back(res);
  endtask

  always @(posedge clk) begin
    outcome_t want;
    if (rst) begin
      width_reg    = WIDTH_RESET;
      interval_reg = INTERVAL_RESET;
      observes     = 0;
      for (int i = 0; i < DEPTH; i++) begin
        counters[i]  = '0;
        gate_bits[i] = 1'b0;
      end
      reseed();
      outcome_q.delete();
    end else begin
      if (cfg_we) begin
        if (cfg_index == CFG_WIDTH_LOG2) width_reg = cfg_data[3:0];
        else interval_reg = cfg_data;
      end
      if (pop && !empty) begin
        if (outcome_q.size() == 0) begin
          $error("unexpected result transfer: admitted %0d, freq_estimate %0d",
                 admitted, freq_estimate);
          mismatches++;
        end else begin
          want = outcome_q.pop_front();
          if (admitted !== want.admit) begin
            $error("admitted: expected %0d, got %0d", want.admit, admitted);
            mismatches++;
          end
          if (freq_estimate !== want.freq) begin
            $error("freq_estimate: expected %0d, got %0d", want.freq, freq_estimate);
            mismatches++;
          end
        end
      end
      if (push && !full) absorb_byte(func, key_byte, key_last);
    end
    pending = outcome_q.size();
  end

endmodule

// File: tb/testbench.sv
`timescale 1ns / 1ps
// Top of the TinyLFU frequency sketch testbench: clock, reset, key stimulus,
// result draining and verdict. Depends on tlfs_pkg, sketch_checker and the block.
module testbench;
  import tlfs_pkg::*;

  localparam int CYCLE_LIMIT = 4000000;
  localparam int SETTLE      = 150;

  logic        clk       = 1'b0;
  logic        rst       = 1'b1;
  logic        cfg_we    = 1'b0;
  logic        cfg_index = CFG_WIDTH_LOG2;
  logic [31:0] cfg_data  = '0;
  logic        push      = 1'b0;
  logic        func      = 1'b0;
  logic [7:0]  key_byte  = 8'd0;
  logic        key_last  = 1'b0;
  logic        pop       = 1'b0;
  logic        full;
  logic        empty;
  logic        admitted;
  logic [3:0]  freq_estimate;
  int          mismatches;
  int          pending;

  // Some phases run with no idling on the key side alone or on both sides.
  bit          push_calm = 1'b0;
  bit          pop_calm  = 1'b0;
  int          bytes_sent = 0;
  int          keys_sent  = 0;
  int          cycles     = 0;

  // A small pool of keys, reused so that observes reach the doorkeeper hit
  // path and counters climb toward saturation.
  logic [7:0]  pool_bytes[16][20];
  int          pool_len[16];

  tinylfu_frequency_sketch_top u_top (
    .clk(clk), .rst(rst), .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .push(push), .full(full), .func(func), .key_byte(key_byte), .key_last(key_last),
    .empty(empty), .pop(pop), .admitted(admitted), .freq_estimate(freq_estimate)
  );

  sketch_checker u_checker (
    .clk(clk), .rst(rst), .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .push(push), .full(full), .func(func), .key_byte(key_byte), .key_last(key_last),
    .empty(empty), .pop(pop), .admitted(admitted), .freq_estimate(freq_estimate),
    .mismatches(mismatches), .pending(pending)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  // Watchdog: a hung handshake ends the run as a failure.
  initial begin
    forever begin
      @(posedge clk);
      cycles++;
      if (cycles > CYCLE_LIMIT) begin
        $display("timeout after %0d cycles", cycles);
        $display("SCOREBOARD MISMATCH");
        $finish;
      end
    end
  end

  // Mostly short gaps, now and then a long one; none at all while calm.
  function automatic int pick_gap(input bit calm);
    int r;
    r = $urandom_range(0, 99);
    if (calm || r < 50) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  // One byte transfer. Push stays high from one byte to the next when there is
  // no gap, so it is never lowered and raised in the same step.
  task automatic send_byte(input logic f, input logic [7:0] b, input logic last);
    int gap;
    bit taken;
    gap = pick_gap(push_calm);
    if (gap > 0) begin
      push <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    push     <= 1'b1;
    func     <= f;
    key_byte <= b;
    key_last <= last;
    do begin
      @(negedge clk);
      taken = !full;
      @(posedge clk);
    end while (!taken);
    bytes_sent++;
  endtask

  task automatic send_key(input logic f, input int slot);
    for (int i = 0; i < pool_len[slot]; i++)
      send_byte($urandom_range(0, 1), pool_bytes[slot][i], 1'b0);
    keys_sent++;
    // Func only matters on the last byte, so the earlier ones carry noise.
  endtask

  task automatic finish_key(input logic f, input int slot);
    send_key(f, slot);
    send_byte(f, pool_bytes[slot][pool_len[slot]], 1'b1);
  endtask

  // A slot holds pool_len leading bytes plus the last byte at index pool_len.
  task automatic fresh_key(input int slot, input int max_len);
    pool_len[slot] = $urandom_range(0, max_len - 1);
    for (int i = 0; i <= pool_len[slot]; i++) pool_bytes[slot][i] = 8'($urandom_range(0, 255));
  endtask

  // Configuration is only touched once every result is back and the back end
  // has had time to finish any work still under way.
  task automatic drain();
    push <= 1'b0;
    do @(negedge clk); while (pending != 0);
    repeat (SETTLE) @(posedge clk);
  endtask

  task automatic set_config(input logic [31:0] width, input logic [31:0] interval);
    drain();
    cfg_we    <= 1'b1;
    cfg_index <= CFG_WIDTH_LOG2;
    cfg_data  <= width;
    @(posedge clk);
    cfg_index <= CFG_DECAY;
    cfg_data  <= interval;
    @(posedge clk);
    cfg_we    <= 1'b0;
  endtask

  // Random traffic over a pool of pool_n keys; now and then a slot gets a new
  // key, and about a third of the keys end as queries.
  task automatic random_phase(input int nbytes, input int pool_n, input int max_len);
    int stop;
    int slot;
    stop = bytes_sent + nbytes;
    for (int s = 0; s < pool_n; s++) fresh_key(s, max_len);
    while (bytes_sent < stop) begin
      slot = $urandom_range(0, pool_n - 1);
      if ($urandom_range(0, 99) < 12) fresh_key(slot, max_len);
      finish_key($urandom_range(0, 99) < 30, slot);
    end
  endtask

  // Result side: pop idles at random and otherwise stays high until a
  // transfer happens.
  initial begin
    int  gap;
    bit  taken;
    @(negedge rst);
    forever begin
      gap = pick_gap(pop_calm);
      if (gap > 0) begin
        pop <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      pop <= 1'b1;
      do begin
        @(negedge clk);
        taken = !empty;
        @(posedge clk);
      end while (!taken);
    end
  end

  initial begin
    repeat (8) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed part at the reset configuration. A one-byte key of all ones is
    // queried, observed three times (first it sets its doorkeeper bits, then it is
    // admitted twice) and queried again. A key containing a zero byte and the
    // extreme byte values follows, and a key never seen is queried.
    pool_len[0] = 0; pool_bytes[0][0] = 8'hFF;
    pool_len[1] = 3;
    pool_bytes[1][0] = 8'h01; pool_bytes[1][1] = 8'h00;
    pool_bytes[1][2] = 8'h80; pool_bytes[1][3] = 8'h7F;
    pool_len[2] = 0; pool_bytes[2][0] = 8'h00;
    pool_len[3] = 1; pool_bytes[3][0] = 8'h55; pool_bytes[3][1] = 8'hAA;
    finish_key(1'b1, 0);
    finish_key(1'b0, 0);
    finish_key(1'b0, 0);
    finish_key(1'b0, 0);
    finish_key(1'b1, 0);
    finish_key(1'b0, 1);
    finish_key(1'b0, 1);
    finish_key(1'b1, 1);
    finish_key(1'b0, 2);
    finish_key(1'b0, 2);
    finish_key(1'b1, 3);

    // Narrowest rows with decay off: heavy collisions and saturated counters.
    set_config(32'd1, 32'd0);
    random_phase(500, 3, 3);

    // A width of zero is taken as one; decay every seven observes.
    set_config(32'd0, 32'd7);
    random_phase(250, 6, 4);

    // Width above the maximum is clamped; the largest interval. No idling here.
    push_calm = 1'b1;
    pop_calm  = 1'b1;
    set_config(32'd15, 32'hFFFF_FFFF);
    random_phase(250, 10, 8);
    push_calm = 1'b0;
    pop_calm  = 1'b0;

    // Mid width with a moderate interval and long keys.
    set_config(32'd4, 32'd20);
    random_phase(250, 8, 20);

    // Build up the observe count, then drop the interval below it so the next
    // observe decays at once; finally decay on every observe.
    set_config(32'd3, 32'd1000);
    random_phase(150, 4, 3);
    push_calm = 1'b1;
    set_config(32'd12, 32'd2);
    random_phase(100, 4, 3);
    push_calm = 1'b0;
    set_config(32'd2, 32'd1);
    random_phase(80, 3, 2);

    drain();
    $display("Sent %0d key bytes in %0d keys over seven configuration phases;",
             bytes_sent, keys_sent);
    $display("widths 0 to 15, decay intervals off, 1, 2, 7, 20, 1000 and maximum.");
    if (mismatches == 0 && pending == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule

// File: tinylfu_frequency_sketch_top.f
+incdir+hw/rtl
hw/rtl/tlfs_pkg.sv
hw/rtl/tlfs_front.sv
hw/rtl/tlfs_cmd_fifo.sv
hw/rtl/tlfs_back.sv
hw/rtl/tinylfu_frequency_sketch_top.sv
hw/rtl/tlfs_checker.sv
tb/sketch_checker.sv
tb/testbench.sv
